### src/d2q9_pkg.sv
// Shared types, constants and fixed-point helpers for the D2Q9 collision pipeline.
package d2q9_pkg;

  localparam int NDIR = 9;
  localparam int QW = 32;
  localparam int FRAC = 28;
  localparam int DIV_STAGES = 32;

  // stage indexes along the side-band line, counted from the divider entry
  localparam int S_UV   = DIV_STAGES + 1;
  localparam int S_SQ   = DIV_STAGES + 2;
  localparam int S_E    = DIV_STAGES + 3;
  localparam int S_C    = DIV_STAGES + 4;
  localparam int S_T    = DIV_STAGES + 5;
  localparam int S_FEQ  = DIV_STAGES + 6;
  localparam int S_PROD = DIV_STAGES + 7;

  typedef logic signed [QW-1:0] q_t;

  localparam q_t QONE = 32'sd268435456;
  localparam q_t QMAX = 32'sh7fffffff;
  localparam q_t QMIN = 32'sh80000000;
  localparam q_t WEIGHT [3] = '{32'sd119304647, 32'sd29826162, 32'sd7456540};

  localparam int DIR_EX   [NDIR] = '{0, 1, 0, -1, 0, 1, -1, -1, 1};
  localparam int DIR_EY   [NDIR] = '{0, 0, 1, 0, -1, 1, 1, -1, -1};
  localparam int DIR_BACK [NDIR] = '{0, 3, 4, 1, 2, 7, 8, 5, 6};
  localparam int DIR_CLS  [NDIR] = '{0, 1, 1, 1, 1, 2, 2, 2, 2};

  typedef struct packed {
    logic                      obs;
    logic [NDIR-1:0][QW-1:0]   f;
    logic [2:0][QW-1:0]        wrho;
    logic                      nx;
    logic                      ny;
    logic                      ovx;
    logic                      ovy;
    logic                      rz;
  } side_t;

  function automatic q_t sat_q(input logic signed [65:0] v);
    if (v > 66'(QMAX)) return QMAX;
    if (v < 66'(QMIN)) return QMIN;
    return v[QW-1:0];
  endfunction

  // product, floor shift by FRAC, saturate
  function automatic q_t qmul(input q_t a, input q_t b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b);
    return sat_q(66'(p >>> FRAC));
  endfunction

  function automatic logic signed [65:0] axis_term(input int e, input q_t u);
    if (e == 1) return 66'(u);
    if (e == -1) return -66'(u);
    return '0;
  endfunction

endpackage

### src/d2q9_bgk_cell_collision.sv
// Top level of the D2Q9 BGK single-cell collision pipeline.
//
// Channels: the slave side takes one cell per beat. s_tdata carries the nine
// propagated Q4.28 densities, s_tuser flags an obstacle cell. The master side
// gives the nine post-collision densities per beat on m_tdata.
// cfg_we/cfg_wdata load omega (unsigned Q2.28); write it only while idle.
//
// Throughput: one cell per cycle unless m_tready stalls. Latency from the
// accepting edge to m_tvalid is set by the 32-stage velocity divider (one
// quotient bit per stage) plus the equilibrium and relaxation multiplies.
//
// Reset (rst, synchronous) clears every valid bit and loads omega = 1.0.
// A stall on m_tready freezes the whole pipe (shared clock enable) and
// drops s_tready in the same cycle, so no beat is lost or repeated; the
// output register holds its beat until taken. Obstacle cells bypass the
// arithmetic and leave as bounce-back at the same latency.
module d2q9_bgk_cell_collision (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  logic [287:0]   s_tdata,   // in_rest, in_east, in_north, in_west, in_south,
                                    // in_northeast, in_northwest, in_southwest,
                                    // in_southeast (32 b each)
  input  logic [0:0]     s_tuser,   // is_obstacle
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [287:0]   m_tdata,   // out_rest .. out_southeast (32 b each)
  input  logic           cfg_we,
  input  logic [29:0]    cfg_wdata  // relaxation_rate
);
  import d2q9_pkg::*;

  logic en;
  assign en = !m_tvalid || m_tready;
  assign s_tready = en;

  logic [29:0] omega;
  always_ff @(posedge clk) begin
    if (rst) begin
      omega <= 30'(QONE);
    end else if (cfg_we) begin
      omega <= cfg_wdata;
    end
  end

  // valid bits: p0, p1, then the side-band line
  logic v0, v1;
  logic vld [0:S_PROD];

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      for (int i = 0; i <= S_PROD; i++) vld[i] <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      v0 <= s_tvalid;
      v1 <= v0;
      vld[0] <= v1;
      for (int i = 1; i <= S_PROD; i++) vld[i] <= vld[i-1];
      m_tvalid <= vld[S_PROD];
    end
  end

  // p0: input register
  q_t   f0 [NDIR];
  logic obs0;
  // p1: density and momentum
  q_t                 f1 [NDIR];
  logic               obs1;
  q_t                 rho1;
  logic signed [35:0] jx1, jy1;
  // p2: divider operands
  logic [30:0] dx_hi, dy_hi;
  logic [31:0] dx_lo, dy_lo, dden;
  side_t       sb [0:S_PROD];

  always_ff @(posedge clk) begin
    logic signed [35:0] sum;
    logic [31:0]        arho;
    logic [34:0]        ajx, ajy;
    if (en) begin
      for (int k = 0; k < NDIR; k++) f0[k] <= s_tdata[QW*k +: QW];
      obs0 <= s_tuser[0];

      sum = '0;
      for (int k = 0; k < NDIR; k++) sum = sum + 36'(f0[k]);
      rho1 <= sat_q(66'(sum));
      jx1 <= 36'(f0[1]) + 36'(f0[5]) + 36'(f0[8]) - 36'(f0[3]) - 36'(f0[6]) - 36'(f0[7]);
      jy1 <= 36'(f0[2]) + 36'(f0[5]) + 36'(f0[6]) - 36'(f0[4]) - 36'(f0[7]) - 36'(f0[8]);
      f1 <= f0;
      obs1 <= obs0;

      // magnitudes; quotient of 2^32 or more is caught by the compare
      arho = rho1[QW-1] ? 32'(-33'(rho1)) : 32'(rho1);
      ajx  = jx1[35] ? 35'(-jx1) : 35'(jx1);
      ajy  = jy1[35] ? 35'(-jy1) : 35'(jy1);
      dx_hi <= ajx[34:4];
      dy_hi <= ajy[34:4];
      dx_lo <= {ajx[3:0], 28'b0};
      dy_lo <= {ajy[3:0], 28'b0};
      dden  <= arho;
      sb[0].obs <= obs1;
      for (int k = 0; k < NDIR; k++) sb[0].f[k] <= f1[k];
      for (int w = 0; w < 3; w++) sb[0].wrho[w] <= qmul(WEIGHT[w], rho1);
      sb[0].nx  <= jx1[35] ^ rho1[QW-1];
      sb[0].ny  <= jy1[35] ^ rho1[QW-1];
      sb[0].ovx <= {1'b0, ajx} >= {arho, 4'b0};
      sb[0].ovy <= {1'b0, ajy} >= {arho, 4'b0};
      sb[0].rz  <= (rho1 == '0);
      for (int i = 1; i <= S_PROD; i++) sb[i] <= sb[i-1];
    end
  end

  logic [31:0] qx, qy;

  d2q9_div u_div_x (
    .clk    (clk),
    .en     (en),
    .num_hi (dx_hi),
    .num_lo (dx_lo),
    .den    (dden),
    .quot   (qx)
  );

  d2q9_div u_div_y (
    .clk    (clk),
    .en     (en),
    .num_hi (dy_hi),
    .num_lo (dy_lo),
    .den    (dden),
    .quot   (qy)
  );

  function automatic q_t vel(input logic [31:0] q, input logic neg, input logic ov,
                             input logic rz);
    q_t mag;
    mag = $signed({1'b0, q[30:0]});
    if (rz) return '0;
    if (ov || q[31]) return neg ? QMIN : QMAX;
    return neg ? -mag : mag;
  endfunction

  q_t ux, uy;                 // S_UV
  q_t uxx, uyy;               // S_SQ
  q_t eu   [1:NDIR-1];
  q_t usq;                    // S_E
  q_t e3   [1:NDIR-1];
  q_t sqe  [1:NDIR-1];
  q_t c;                      // S_C
  q_t e3c  [1:NDIR-1];
  q_t e45  [1:NDIR-1];
  q_t t    [NDIR];            // S_T
  q_t feq  [NDIR];            // S_FEQ
  logic signed [63:0] prod [NDIR];  // S_PROD

  always_ff @(posedge clk) begin
    logic signed [32:0] diff;
    side_t              so;
    if (en) begin
      ux <= vel(qx, sb[DIV_STAGES].nx, sb[DIV_STAGES].ovx, sb[DIV_STAGES].rz);
      uy <= vel(qy, sb[DIV_STAGES].ny, sb[DIV_STAGES].ovy, sb[DIV_STAGES].rz);

      uxx <= qmul(ux, ux);
      uyy <= qmul(uy, uy);
      for (int k = 1; k < NDIR; k++)
        eu[k] <= sat_q(axis_term(DIR_EX[k], ux) + axis_term(DIR_EY[k], uy));

      usq <= sat_q(66'(uxx) + 66'(uyy));
      for (int k = 1; k < NDIR; k++) begin
        e3[k]  <= sat_q(66'(eu[k]) * 66'sd3);
        sqe[k] <= qmul(eu[k], eu[k]);
      end

      // times 1.5 and 4.5 are exact: multiply, then floor-halve
      c <= sat_q((66'(usq) * 66'sd3) >>> 1);
      for (int k = 1; k < NDIR; k++) begin
        e3c[k] <= e3[k];
        e45[k] <= sat_q((66'(sqe[k]) * 66'sd9) >>> 1);
      end

      t[0] <= sat_q(66'(QONE) - 66'(c));
      for (int k = 1; k < NDIR; k++)
        t[k] <= sat_q(66'(QONE) + 66'(e3c[k]) + 66'(e45[k]) - 66'(c));

      for (int k = 0; k < NDIR; k++)
        feq[k] <= qmul($signed(sb[S_T].wrho[DIR_CLS[k]]), t[k]);

      for (int k = 0; k < NDIR; k++) begin
        diff = 33'(feq[k]) - 33'($signed(sb[S_FEQ].f[k]));
        prod[k] <= 64'($signed({1'b0, omega})) * 64'(diff);
      end

      so = sb[S_PROD];
      for (int k = 0; k < NDIR; k++) begin
        if (so.obs) begin
          m_tdata[QW*k +: QW] <= so.f[DIR_BACK[k]];
        end else begin
          m_tdata[QW*k +: QW] <= sat_q(66'($signed(so.f[k])) + 66'(prod[k] >>> FRAC));
        end
      end
    end
  end

endmodule

### src/d2q9_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module d2q9_div (
  input  logic        clk,
  input  logic        en,
  input  logic [30:0] num_hi,  // dividend bits above 31
  input  logic [31:0] num_lo,  // dividend bits 31..0
  input  logic [31:0] den,
  output logic [31:0] quot
);
  import d2q9_pkg::*;

  logic [31:0] r_rem [1:DIV_STAGES];
  logic [31:0] r_lo  [1:DIV_STAGES];
  logic [31:0] r_den [1:DIV_STAGES];
  logic [31:0] r_q   [1:DIV_STAGES];

  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stage
    logic [31:0] pr, plo, pd, pq;
    logic [32:0] t;
    logic        ge;
    if (i == 0) begin : g_first
      assign pr  = {1'b0, num_hi};
      assign plo = num_lo;
      assign pd  = den;
      assign pq  = '0;
    end else begin : g_next
      assign pr  = r_rem[i];
      assign plo = r_lo[i];
      assign pd  = r_den[i];
      assign pq  = r_q[i];
    end
    assign t  = {pr, plo[31]};
    assign ge = t >= {1'b0, pd};
    always_ff @(posedge clk) begin
      if (en) begin
        r_rem[i+1] <= ge ? 32'(t - {1'b0, pd}) : 32'(t);
        r_lo[i+1]  <= {plo[30:0], 1'b0};
        r_den[i+1] <= pd;
        r_q[i+1]   <= {pq[30:0], ge};
      end
    end
  end

  assign quot = r_q[DIV_STAGES];

endmodule

### test/tb.sv
// Testbench for the D2Q9 BGK cell collision pipeline: random and directed cells, scoreboard.
`timescale 1ns / 1ps

module tb;
  import d2q9_pkg::*;

  typedef logic signed [63:0] w64_t;

  // Expected-cell store and checker
  class cell_scoreboard;
    logic [287:0] pending [$];
    int errors;

    function void note_cell(input logic [287:0] beat);
      pending.push_back(beat);
    endfunction

    function void check_cell(input logic [287:0] got);
      logic [287:0] want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected beat, actual %h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      for (int k = 0; k < 9; k++) begin
        if (want[32*k +: 32] !== got[32*k +: 32]) begin
          $display("%0t: dir %0d expected %h actual %h", $time, k,
                   want[32*k +: 32], got[32*k +: 32]);
          errors++;
        end
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [287:0] s_tdata = '0;
  logic [0:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [287:0] m_tdata;
  logic cfg_we = 0;
  logic [29:0] cfg_wdata = '0;

  cell_scoreboard sb = new();
  logic [29:0] omega_model = 30'd268435456;
  bit calm = 0;        // no idling in the last stretch
  bit sink_ok = 1;

  always #5 clk = ~clk;

  d2q9_bgk_cell_collision uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  function automatic w64_t sat(input w64_t v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // exact product, floor shift, saturate (operands fit 32 bits)
  function automatic w64_t fxmul(input w64_t a, input w64_t b);
    w64_t p;
    p = a * b;
    return sat(p >>> 28);
  endfunction

  function automatic w64_t fxdiv(input w64_t num, input w64_t den);
    w64_t q;
    if (den == 0) return 0;
    q = (num * 64'sd268435456) / den;   // SV division truncates toward zero
    return sat(q);
  endfunction

  // Expected post-collision cell
  function automatic logic [287:0] collide(input logic obs, input logic [287:0] beat,
                                           input logic [29:0] omega);
    w64_t f [9];
    w64_t res [9];
    w64_t rho, jx, jy, ux, uy, usq, c, eu, t, feq, diff, wt;
    int ex [9] = '{0, 1, 0, -1, 0, 1, -1, -1, 1};
    int ey [9] = '{0, 0, 1, 0, -1, 1, 1, -1, -1};
    int back [9] = '{0, 3, 4, 1, 2, 7, 8, 5, 6};
    logic [287:0] out;
    for (int k = 0; k < 9; k++) f[k] = w64_t'($signed(beat[32*k +: 32]));
    if (obs) begin
      for (int k = 0; k < 9; k++) res[k] = f[back[k]];
    end else begin
      rho = 0;
      for (int k = 0; k < 9; k++) rho += f[k];
      rho = sat(rho);
      jx = f[1] + f[5] + f[8] - (f[3] + f[6] + f[7]);
      jy = f[2] + f[5] + f[6] - (f[4] + f[7] + f[8]);
      ux = fxdiv(jx, rho);
      uy = fxdiv(jy, rho);
      usq = sat(fxmul(ux, ux) + fxmul(uy, uy));
      c = fxmul(usq, 64'sd402653184);
      for (int k = 0; k < 9; k++) begin
        if (k == 0) begin
          t = sat(64'sd268435456 - c);
          wt = 64'sd119304647;
        end else begin
          eu = sat(w64_t'(ex[k]) * ux + w64_t'(ey[k]) * uy);
          t = sat(64'sd268435456 + fxmul(64'sd805306368, eu)
                  + fxmul(64'sd1207959552, fxmul(eu, eu)) - c);
          wt = (k < 5) ? 64'sd29826162 : 64'sd7456540;
        end
        feq = fxmul(fxmul(wt, rho), t);
        diff = feq - f[k];
        res[k] = sat(f[k] + ((w64_t'({34'b0, omega}) * diff) >>> 28));
      end
    end
    for (int k = 0; k < 9; k++) out[32*k +: 32] = res[k][31:0];
    return out;
  endfunction

  // Result side: sample at rising edge, change ready at falling edge
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_cell(m_tdata);
  end

  initial begin
    int gap;
    @(negedge clk);
    forever begin
      if (calm || !sink_ok) begin
        m_tready <= 1;
        @(negedge clk);
      end else if ($urandom_range(0, 3) == 0) begin
        gap = $urandom_range(1, 12);
        m_tready <= 0;
        repeat (gap) @(negedge clk);
      end else begin
        m_tready <= 1;
        repeat ($urandom_range(1, 20)) @(negedge clk);
      end
    end
  end

  // One beat, with an optional idle burst before it
  task automatic send_cell(input logic obs, input logic [287:0] beat);
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= beat;
    s_tuser <= obs;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_cell(collide(obs, beat, omega_model));
    @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
  endtask

  task automatic set_omega(input logic [29:0] w);
    cfg_we <= 1;
    cfg_wdata <= w;
    @(negedge clk);
    cfg_we <= 0;
    omega_model = w;
  endtask

  // Random density near a realistic fluid state, or a wild word
  function automatic logic [31:0] rand_dens(input bit wild);
    if (wild) return $urandom;
    return 32'($urandom_range(0, 60000000)) - 32'd10000000;
  endfunction

  task automatic rand_cell(input bit wild);
    logic [287:0] beat;
    for (int k = 0; k < 9; k++) beat[32*k +: 32] = rand_dens(wild);
    send_cell($urandom_range(0, 7) == 0, beat);
  endtask

  initial begin
    logic [287:0] beat;
    logic [29:0] omegas [5] = '{30'd0, 30'h3fffffff, 30'd134217728,
                                30'd456340275, 30'd268435456};
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // directed: extremes, obstacle, zero density, at reset omega
    send_cell(0, '0);
    send_cell(1, '0);
    send_cell(0, {9{32'h7fffffff}});
    send_cell(0, {9{32'h80000000}});
    send_cell(1, {9{32'h80000000}});
    send_cell(1, {9{32'h7fffffff}});
    for (int k = 0; k < 9; k++) begin
      beat = {9{32'd29826162}};
      beat[32*k +: 32] = 32'h7fffffff;
      send_cell(0, beat);
      beat[32*k +: 32] = 32'h80000000;
      send_cell(k[0], beat);
    end
    // opposite flows cancel to zero total density
    send_cell(0, {32'sd100, 32'sd100, -32'sd100, -32'sd100, 32'sd0,
                  32'sd0, 32'sd0, 32'sd0, 32'sd0});
    send_cell(0, {32'h5555_5555, 32'haaaa_aaaa, {7{32'd0}}});
    send_cell(1, {32'haaaa_aaaa, 32'h5555_5555, {7{32'd1}}});

    // sender holds off until everything is back
    drain();

    // random phases over several omega settings
    for (int p = 0; p < 5; p++) begin
      set_omega(omegas[p]);
      for (int i = 0; i < 215; i++) begin
        if (p == 4 && i == 165) calm = 1;
        rand_cell($urandom_range(0, 4) == 0);
      end
      drain();
    end
    s_tvalid <= 0;

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("FAIL");
    $finish;
  end

endmodule
